[hw/rtl/bpq_pkg.sv]
package bpq_pkg;

   // Queue geometry.
   localparam int LEVELS    = 16;
   localparam int CAPACITY  = 256;
   localparam int ELEM_BITS = 32;

   localparam int LVL_W  = $clog2(LEVELS);
   localparam int SLOT_W = $clog2(CAPACITY);
   localparam int CNT_W  = $clog2(CAPACITY + 1);

   // Stream payload layout, fields packed from bit 0 upward.
   localparam int REQ_PRIO_LSB  = ELEM_BITS;
   localparam int REQ_DATA_W    = ((ELEM_BITS + LVL_W + 7) / 8) * 8;
   localparam int RSP_PRIO_LSB  = ELEM_BITS;
   localparam int RSP_CNT_LSB   = ELEM_BITS + LVL_W;
   localparam int RSP_EMPTY_BIT = ELEM_BITS + LVL_W + CNT_W;
   localparam int RSP_DATA_W    = ((ELEM_BITS + LVL_W + CNT_W + 1 + 7) / 8) * 8;

   // Kind of request transaction.
   typedef enum logic {
      REQ_ENQ = 1'b0,
      REQ_DEQ = 1'b1
   } req_kind_type;

   // Result status codes.
   typedef enum logic [1:0] {
      STAT_OK        = 2'd0,
      STAT_PRIO_HIGH = 2'd1,
      STAT_DEQ_EMPTY = 2'd2,
      STAT_FULL      = 2'd3
   } status_type;

   typedef enum logic {
      ST_IDLE   = 1'b0,
      ST_UPDATE = 1'b1
   } state_type;

   typedef struct packed {
      logic             found;
      logic [LVL_W-1:0] idx;
   } lvl_pick_type;

   // Lowest-numbered level whose bit is set.
   function automatic lvl_pick_type first_level(input logic [LEVELS-1:0] ne);
      lvl_pick_type pick;
      pick.found = 1'b0;
      pick.idx   = '0;
      for (int i = LEVELS - 1; i >= 0; i--) begin
         if (ne[LVL_W'(i)]) begin
            pick.found = 1'b1;
            pick.idx   = LVL_W'(i);
         end
      end
      return pick;
   endfunction

endpackage

[hw/rtl/bucketed_priority_queue_core.sv]
// Channel  Direction  Fields (from bit 0 up)
// req      in         tuser: req_type; tdata: element, priority_req, zero pad
// rsp      out        tuser: status; tdata: head_element, head_priority, count,
//                     is_empty, zero pad
// csr      in         csr_wr_data: max_level, written when csr_wr_en is high
//
// Each transaction has an accept cycle and an update cycle: the accept cycle reads the link
// memory (a dequeue also pushes its slot on the free list), and the update cycle writes
// the element, links and level tables and reads the element memory for the new head.
// That read is registered, then loaded into the output register that drives rsp_tvalid;
// the next request can be accepted in the cycle of that load while rsp keeps up. Reset is
// synchronous and leaves the queue empty. A stalled rsp blocks new requests once a second result waits.
module bucketed_priority_queue_core
   import bpq_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // element, priority_req
   input  logic                  req_tuser,   // req_type
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // head_element, head_priority, count, is_empty
   output logic [1:0]            rsp_tuser,   // status
   input  logic                  csr_wr_en,
   input  logic [LVL_W-1:0]      csr_wr_data
);

   // Control state.
   state_type         state_ff, state_in;
   logic [LVL_W-1:0]  max_level_ff;
   logic [LEVELS-1:0] nonempty_ff, nonempty_in;
   logic [SLOT_W-1:0] free_head_ff, free_head_in;
   logic [CNT_W-1:0]  fresh_fill_ff, fresh_fill_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              cap_pend_ff, cap_pend_in;
   logic              rsp_valid_ff, rsp_valid_in;

   // Per-transaction context kept from accept to update.
   logic                 op_enq_ff, op_enq_in;
   logic                 op_ok_ff, op_ok_in;
   status_type           status_ff, status_in;
   logic                 use_free_ff, use_free_in;
   logic [SLOT_W-1:0]    slot_ff, slot_in;
   logic [LVL_W-1:0]     prio_ff, prio_in;
   logic [ELEM_BITS-1:0] elem_ff, elem_in;
   logic                 last_ff, last_in;
   logic [LVL_W-1:0]     lvl_ff, lvl_in;

   // Result context kept until the element read returns.
   logic                 cap_fwd_ff, cap_fwd_in;
   logic [ELEM_BITS-1:0] cap_elem_ff;
   logic                 cap_empty_ff, cap_empty_in;
   logic [LVL_W-1:0]     cap_prio_ff, cap_prio_in;
   logic [CNT_W-1:0]     cap_count_ff;
   status_type           cap_status_ff;

   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic [1:0]            rsp_user_ff, rsp_user_in;

   // Level head and tail tables.
   logic [SLOT_W-1:0] level_head_ff [LEVELS];
   logic [SLOT_W-1:0] level_tail_ff [LEVELS];
   logic              head_we, tail_we;
   logic [LVL_W-1:0]  head_widx, tail_widx;
   logic [SLOT_W-1:0] head_wdata, tail_wdata;

   // Element and link memories.
   logic [ELEM_BITS-1:0] elem_mem [CAPACITY];
   logic [SLOT_W-1:0]    link_mem [CAPACITY];
   logic [ELEM_BITS-1:0] elem_rd_ff;
   logic [SLOT_W-1:0]    link_rd_ff;
   logic                 elem_we, elem_re, link_we, link_re;
   logic [SLOT_W-1:0]    elem_waddr, elem_raddr, link_waddr, link_raddr, link_wdata;

   logic                 accept, load_ok, cap_load;
   lvl_pick_type         cur_first, new_first;
   logic [LEVELS-1:0]    ne_upd;
   logic [LVL_W-1:0]     head_idx, tail_idx;
   logic [SLOT_W-1:0]    head_sel, tail_sel;
   logic [LVL_W-1:0]     in_prio;
   logic [ELEM_BITS-1:0] in_elem;
   logic                 free_avail, fresh_avail;

   // Handshake and table read selection.
   assign load_ok    = !rsp_valid_ff || rsp_tready;
   assign cap_load   = cap_pend_ff && load_ok;
   assign req_tready = (state_ff == ST_IDLE) && (!cap_pend_ff || load_ok);
   assign accept     = req_tvalid && req_tready;

   assign in_elem = req_tdata[ELEM_BITS-1:0];
   assign in_prio = req_tdata[REQ_PRIO_LSB +: LVL_W];

   assign cur_first = first_level(nonempty_ff);
   assign ne_upd    = (op_enq_ff && op_ok_ff) ? (nonempty_ff | (LEVELS'(1) << prio_ff))
                                              : nonempty_ff;
   assign new_first = first_level(ne_upd);

   assign head_idx = (state_ff == ST_IDLE) ? cur_first.idx : new_first.idx;
   assign tail_idx = (state_ff == ST_IDLE) ? cur_first.idx : prio_ff;
   assign head_sel = level_head_ff[head_idx];
   assign tail_sel = level_tail_ff[tail_idx];

   assign free_avail  = count_ff < fresh_fill_ff;
   assign fresh_avail = fresh_fill_ff < CNT_W'(CAPACITY);

   // Next state and memory controls.
   always_comb begin
      state_in      = state_ff;
      nonempty_in   = nonempty_ff;
      free_head_in  = free_head_ff;
      fresh_fill_in = fresh_fill_ff;
      count_in      = count_ff;
      cap_pend_in   = cap_pend_ff;
      op_enq_in     = op_enq_ff;
      op_ok_in      = op_ok_ff;
      status_in     = status_ff;
      use_free_in   = use_free_ff;
      slot_in       = slot_ff;
      prio_in       = prio_ff;
      elem_in       = elem_ff;
      last_in       = last_ff;
      lvl_in        = lvl_ff;
      cap_fwd_in    = cap_fwd_ff;
      cap_empty_in  = cap_empty_ff;
      cap_prio_in   = cap_prio_ff;
      head_we       = 1'b0;
      head_widx     = prio_ff;
      head_wdata    = slot_ff;
      tail_we       = 1'b0;
      tail_widx     = prio_ff;
      tail_wdata    = slot_ff;
      elem_we       = 1'b0;
      elem_waddr    = slot_ff;
      elem_re       = 1'b0;
      elem_raddr    = head_sel;
      link_we       = 1'b0;
      link_waddr    = head_sel;
      link_wdata    = free_head_ff;
      link_re       = 1'b0;
      link_raddr    = free_head_ff;

      if (cap_load) begin
         cap_pend_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in  = ST_UPDATE;
               op_enq_in = (req_kind_type'(req_tuser) == REQ_ENQ);
               prio_in   = in_prio;
               elem_in   = in_elem;
               op_ok_in  = 1'b0;
               if (req_kind_type'(req_tuser) == REQ_ENQ) begin
                  // Enqueue: check level, then pick a slot.
                  use_free_in = free_avail;
                  slot_in     = free_avail ? free_head_ff : fresh_fill_ff[SLOT_W-1:0];
                  if (in_prio > max_level_ff || int'(in_prio) >= LEVELS) begin
                     status_in = STAT_PRIO_HIGH;
                  end else if (!free_avail && !fresh_avail) begin
                     status_in = STAT_FULL;
                  end else begin
                     status_in = STAT_OK;
                     op_ok_in  = 1'b1;
                     count_in  = count_ff + CNT_W'(1);
                     if (free_avail) begin
                        link_re    = 1'b1;
                        link_raddr = free_head_ff;
                     end else begin
                        fresh_fill_in = fresh_fill_ff + CNT_W'(1);
                     end
                  end
               end else begin
                  // Dequeue: unlink the head of the most urgent level.
                  slot_in = head_sel;
                  last_in = (head_sel == tail_sel);
                  lvl_in  = cur_first.idx;
                  if (!cur_first.found) begin
                     status_in = STAT_DEQ_EMPTY;
                  end else begin
                     status_in    = STAT_OK;
                     op_ok_in     = 1'b1;
                     link_re      = 1'b1;
                     link_raddr   = head_sel;
                     link_we      = 1'b1;
                     link_waddr   = head_sel;
                     link_wdata   = free_head_ff;
                     free_head_in = head_sel;
                     count_in     = count_ff - CNT_W'(1);
                     if (head_sel == tail_sel) begin
                        nonempty_in[cur_first.idx] = 1'b0;
                     end
                  end
               end
            end
         end
         ST_UPDATE: begin
            state_in    = ST_IDLE;
            cap_pend_in = 1'b1;
            if (op_ok_ff && op_enq_ff) begin
               // Store the element and append the slot to its level.
               if (use_free_ff) begin
                  free_head_in = link_rd_ff;
               end
               elem_we    = 1'b1;
               elem_waddr = slot_ff;
               if (nonempty_ff[prio_ff]) begin
                  link_we    = 1'b1;
                  link_waddr = tail_sel;
                  link_wdata = slot_ff;
               end else begin
                  head_we = 1'b1;
               end
               tail_we     = 1'b1;
               nonempty_in = ne_upd;
            end else if (op_ok_ff && !last_ff) begin
               head_we    = 1'b1;
               head_widx  = lvl_ff;
               head_wdata = link_rd_ff;
            end
            // Fetch the new front element, or take it straight from the request.
            cap_fwd_in   = op_ok_ff && op_enq_ff && new_first.idx == prio_ff
                           && !nonempty_ff[prio_ff];
            cap_empty_in = !new_first.found;
            cap_prio_in  = new_first.found ? new_first.idx : '0;
            elem_re      = 1'b1;
            if (op_ok_ff && !op_enq_ff && !last_ff && new_first.idx == lvl_ff) begin
               elem_raddr = link_rd_ff;
            end else begin
               elem_raddr = head_sel;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Output register.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      if (cap_load) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = '0;
         rsp_data_in[ELEM_BITS-1:0] = cap_empty_ff ? '0 :
                                      (cap_fwd_ff ? cap_elem_ff : elem_rd_ff);
         rsp_data_in[RSP_PRIO_LSB +: LVL_W] = cap_prio_ff;
         rsp_data_in[RSP_CNT_LSB +: CNT_W]  = cap_count_ff;
         rsp_data_in[RSP_EMPTY_BIT]         = cap_empty_ff;
         rsp_user_in  = cap_status_ff;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         max_level_ff  <= LVL_W'(LEVELS - 1);
         nonempty_ff   <= '0;
         free_head_ff  <= '0;
         fresh_fill_ff <= '0;
         count_ff      <= '0;
         cap_pend_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         nonempty_ff   <= nonempty_in;
         free_head_ff  <= free_head_in;
         fresh_fill_ff <= fresh_fill_in;
         count_ff      <= count_in;
         cap_pend_ff   <= cap_pend_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (csr_wr_en) begin
            max_level_ff <= csr_wr_data;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      op_enq_ff    <= op_enq_in;
      op_ok_ff     <= op_ok_in;
      status_ff    <= status_in;
      use_free_ff  <= use_free_in;
      slot_ff      <= slot_in;
      prio_ff      <= prio_in;
      elem_ff      <= elem_in;
      last_ff      <= last_in;
      lvl_ff       <= lvl_in;
      cap_fwd_ff   <= cap_fwd_in;
      cap_empty_ff <= cap_empty_in;
      cap_prio_ff  <= cap_prio_in;
      rsp_data_ff  <= rsp_data_in;
      rsp_user_ff  <= rsp_user_in;
      if (state_ff == ST_UPDATE) begin
         cap_elem_ff   <= elem_ff;
         cap_count_ff  <= count_ff;
         cap_status_ff <= status_ff;
      end
   end

   // Level head and tail tables.
   always_ff @(posedge clock) begin
      if (head_we) begin
         level_head_ff[head_widx] <= head_wdata;
      end
      if (tail_we) begin
         level_tail_ff[tail_widx] <= tail_wdata;
      end
   end

   // Element memory.
   always_ff @(posedge clock) begin
      if (elem_we) begin
         elem_mem[elem_waddr] <= elem_ff;
      end
      if (elem_re) begin
         elem_rd_ff <= elem_mem[elem_raddr];
      end
   end

   // Link memory: next slot within a level, or within the free list.
   always_ff @(posedge clock) begin
      if (link_we) begin
         link_mem[link_waddr] <= link_wdata;
      end
      if (link_re) begin
         link_rd_ff <= link_mem[link_raddr];
      end
   end

endmodule

[hw/rtl/bpq_checker.sv]
module bpq_checker
   import bpq_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tvalid,
   input logic                  req_tready,
   input logic [REQ_DATA_W-1:0] req_tdata,
   input logic                  req_tuser,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata,
   input logic [1:0]            rsp_tuser,
   input logic                  csr_wr_en,
   input logic [LVL_W-1:0]      csr_wr_data
);

   logic [CNT_W-1:0] rsp_count;
   logic             rsp_empty;

   assign rsp_count = rsp_tdata[RSP_CNT_LSB +: CNT_W];
   assign rsp_empty = rsp_tdata[RSP_EMPTY_BIT];

   // A stalled result transaction keeps its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result changed while stalled");

   // The empty flag agrees with the count.
   a_empty_count: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_empty == (rsp_count == '0)))
      else $error("empty flag disagrees with count");

   // An empty queue reports a zero head.
   a_empty_head: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_empty
      |-> rsp_tdata[ELEM_BITS-1:0] == '0 && rsp_tdata[RSP_PRIO_LSB +: LVL_W] == '0)
      else $error("empty queue reports a head element");

   // The count never exceeds capacity, and a full report means a full queue.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_count <= CNT_W'(CAPACITY))
      else $error("count above capacity");

   a_full_status: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == STAT_FULL |-> rsp_count == CNT_W'(CAPACITY))
      else $error("full status with free slots");

endmodule

bind bucketed_priority_queue_core bpq_checker u_bpq_checker (.*);

[dv/tb_top.sv]
`timescale 1ns / 100ps

module tb_top
   import bpq_pkg::*;
();

   // Snapshot of the queue as one result transaction reports it.
   typedef struct {
      logic [ELEM_BITS-1:0] head_elem;
      logic [LVL_W-1:0]     head_lvl;
      logic [CNT_W-1:0]     count;
      logic                 empty;
      status_type           status;
   } queue_view_type;

   localparam int STALL_LIMIT = 1000;

   logic                  clock       = 1'b0;
   logic                  reset       = 1'b1;
   logic                  req_tvalid  = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata   = '0;   // element, priority_req
   logic                  req_tuser   = 1'b0; // req_type
   logic                  rsp_tvalid;
   logic                  rsp_tready  = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;          // head_element, head_priority, count, is_empty
   logic [1:0]            rsp_tuser;          // status
   logic                  csr_wr_en   = 1'b0;
   logic [LVL_W-1:0]      csr_wr_data = '0;

   // Shadow copy of the queue storage and its bookkeeping.
   logic [ELEM_BITS-1:0] elem_mem [CAPACITY];
   logic [SLOT_W-1:0]    link_mem [CAPACITY];
   logic [SLOT_W-1:0]    lvl_head [LEVELS];
   logic [SLOT_W-1:0]    lvl_tail [LEVELS];
   logic [LEVELS-1:0]    lvl_busy  = '0;
   logic [SLOT_W-1:0]    free_top  = '0;
   int                   fresh_cnt = 0;
   int                   stored    = 0;
   logic [LVL_W-1:0]     max_lvl   = LVL_W'(LEVELS - 1);

   queue_view_type pending_views[$];

   int mismatches  = 0;
   int idle_cycles = 0;
   int rsp_wait    = 0;
   bit req_idle_on = 1'b1;
   bit rsp_idle_on = 1'b1;

   bucketed_priority_queue_core DUT (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #5 clock = ~clock;

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      mismatches++;
      $display("ERROR at %0t: %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
   endtask

   // Lowest-numbered level that holds an entry, or -1 when the queue is empty.
   function automatic int most_urgent_level();
      for (int lv = 0; lv < LEVELS; lv++) begin
         if (lvl_busy[LVL_W'(lv)]) begin
            return lv;
         end
      end
      return -1;
   endfunction

   // Applies one request to the shadow queue and returns the state it reports.
   function automatic queue_view_type apply_request(input req_kind_type kind,
                                                    input logic [ELEM_BITS-1:0] elem,
                                                    input logic [LVL_W-1:0] prio);
      queue_view_type    view;
      logic [SLOT_W-1:0] slot;
      int                lv;
      view.status = STAT_OK;
      if (kind == REQ_ENQ) begin
         if (prio > max_lvl) begin
            view.status = STAT_PRIO_HIGH;
         end else if (stored == CAPACITY) begin
            view.status = STAT_FULL;
         end else begin
            // Recycle the most recently released slot before a fresh one.
            if (stored < fresh_cnt) begin
               slot     = free_top;
               free_top = link_mem[slot];
            end else begin
               slot = SLOT_W'(fresh_cnt);
               fresh_cnt++;
            end
            elem_mem[slot] = elem;
            link_mem[slot] = '0;
            if (lvl_busy[prio]) begin
               link_mem[lvl_tail[prio]] = slot;
            end else begin
               lvl_head[prio] = slot;
               lvl_busy[prio] = 1'b1;
            end
            lvl_tail[prio] = slot;
            stored++;
         end
      end else begin
         lv = most_urgent_level();
         if (lv < 0) begin
            view.status = STAT_DEQ_EMPTY;
         end else begin
            slot = lvl_head[LVL_W'(lv)];
            if (slot == lvl_tail[LVL_W'(lv)]) begin
               lvl_busy[LVL_W'(lv)] = 1'b0;
            end else begin
               lvl_head[LVL_W'(lv)] = link_mem[slot];
            end
            link_mem[slot] = free_top;
            free_top       = slot;
            stored--;
         end
      end

      // Describe the queue after the update.
      lv = most_urgent_level();
      if (lv >= 0) begin
         view.head_elem = elem_mem[lvl_head[LVL_W'(lv)]];
         view.head_lvl  = LVL_W'(lv);
      end else begin
         view.head_elem = '0;
         view.head_lvl  = '0;
      end
      view.count = CNT_W'(stored);
      view.empty = (stored == 0);
      return view;
   endfunction

   // Sends one request, after a random gap if req_idle_on is set, and records what it should report.
   task automatic issue_request(input req_kind_type kind, input logic [ELEM_BITS-1:0] elem,
                                input logic [LVL_W-1:0] prio);
      int gap;
      gap = req_idle_on ? $urandom_range(0, 5) : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= REQ_DATA_W'({prio, elem});
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pending_views.push_back(apply_request(kind, elem, prio));
   endtask

   // Waits until every result has come back and the block has gone quiet.
   task automatic settle_queue();
      req_tvalid <= 1'b0;
      while (pending_views.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_max_level(input logic [LVL_W-1:0] level);
      settle_queue();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= level;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      max_lvl = level;
   endtask

   // Random mix of enqueues and dequeues; most priorities are legal for the current limit.
   task automatic run_traffic(input int items, input int deq_pct);
      req_kind_type         kind;
      logic [ELEM_BITS-1:0] elem;
      logic [LVL_W-1:0]     prio;
      int                   pick;
      repeat (items) begin
         kind = ($urandom_range(0, 99) < deq_pct) ? REQ_DEQ : REQ_ENQ;
         pick = $urandom_range(0, 9);
         if (pick == 0) begin
            elem = '0;
         end else if (pick == 1) begin
            elem = '1;
         end else begin
            elem = ELEM_BITS'($urandom());
         end
         if ($urandom_range(0, 99) < 85) begin
            prio = LVL_W'($urandom_range(0, max_lvl));
         end else begin
            prio = LVL_W'($urandom_range(0, LEVELS - 1));
         end
         issue_request(kind, elem, prio);
      end
   endtask

   // Ordering across levels, extreme elements, empty dequeue and the tightest limit.
   task automatic test_directed_basics();
      issue_request(REQ_DEQ, 32'hDEADBEEF, 4'd3);
      issue_request(REQ_ENQ, 32'hFFFFFFFF, 4'd15);
      issue_request(REQ_ENQ, 32'h00000000, 4'd0);
      issue_request(REQ_ENQ, 32'h5A5A5A5A, 4'd7);
      issue_request(REQ_ENQ, 32'h12345678, 4'd0);
      repeat (4) issue_request(REQ_DEQ, 32'h0, 4'd0);
      issue_request(REQ_DEQ, 32'hFFFFFFFF, 4'd15);
      set_max_level(4'd0);
      issue_request(REQ_ENQ, 32'h00000001, 4'd1);
      issue_request(REQ_ENQ, 32'h80000001, 4'd0);
      issue_request(REQ_ENQ, 32'hA5A5A5A5, 4'd15);
      issue_request(REQ_DEQ, 32'h0, 4'd0);
   endtask

   // Entries above a lowered limit stay queued and still come out in order.
   task automatic test_lowered_max_level();
      set_max_level(4'd15);
      issue_request(REQ_ENQ, 32'hC0000012, 4'd12);
      issue_request(REQ_ENQ, 32'hC0000014, 4'd14);
      issue_request(REQ_ENQ, 32'hC0000003, 4'd3);
      set_max_level(4'd2);
      issue_request(REQ_ENQ, 32'hBAD00003, 4'd3);
      issue_request(REQ_ENQ, 32'hC0000002, 4'd2);
      repeat (5) issue_request(REQ_DEQ, 32'h0, 4'd0);
   endtask

   // Fill every slot, hit the full and too-high cases, then drain past empty.
   task automatic test_fill_and_drain();
      set_max_level(4'd9);
      repeat (CAPACITY) begin
         issue_request(REQ_ENQ, ELEM_BITS'($urandom()), LVL_W'($urandom_range(0, 9)));
      end
      issue_request(REQ_ENQ, 32'h0BADF00D, 4'd12);
      issue_request(REQ_ENQ, 32'h0FEEDBAC, 4'd4);
      repeat (CAPACITY + 1) begin
         issue_request(REQ_DEQ, ELEM_BITS'($urandom()), LVL_W'($urandom_range(0, 15)));
      end
   endtask

   // Random phases under different limits and flow-control patterns.
   task automatic test_random_traffic();
      set_max_level(4'd6);
      req_idle_on = 1'b1;
      rsp_idle_on = 1'b1;
      run_traffic(150, 35);

      set_max_level(4'd15);
      req_idle_on = 1'b0;
      rsp_idle_on = 1'b0;
      run_traffic(150, 45);

      set_max_level(LVL_W'($urandom_range(0, LEVELS - 1)));
      req_idle_on = 1'b1;
      rsp_idle_on = 1'b0;
      run_traffic(150, 50);

      set_max_level(LVL_W'($urandom_range(0, LEVELS - 1)));
      req_idle_on = 1'b0;
      rsp_idle_on = 1'b1;
      run_traffic(150, 60);
      req_idle_on = 1'b1;
   endtask

   // Result side flow control: ready may be held off after each transaction while rsp_idle_on is set.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (rsp_tvalid && rsp_tready) begin
         rsp_wait = rsp_idle_on ? $urandom_range(0, 5) : 0;
         rsp_tready <= (rsp_wait == 0);
      end else if (rsp_wait > 0) begin
         rsp_wait--;
         rsp_tready <= (rsp_wait == 0);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Compare each result transaction with the oldest expected queue state.
   always @(posedge clock) begin : result_check
      queue_view_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_views.size() == 0) begin
            report_mismatch("result with nothing expected", 64'(rsp_tdata), 64'h0);
         end else begin
            want = pending_views.pop_front();
            if (rsp_tdata[ELEM_BITS-1:0] !== want.head_elem)
               report_mismatch("head_element", 64'(rsp_tdata[ELEM_BITS-1:0]),
                               64'(want.head_elem));
            if (rsp_tdata[RSP_PRIO_LSB +: LVL_W] !== want.head_lvl)
               report_mismatch("head_priority", 64'(rsp_tdata[RSP_PRIO_LSB +: LVL_W]),
                               64'(want.head_lvl));
            if (rsp_tdata[RSP_CNT_LSB +: CNT_W] !== want.count)
               report_mismatch("count", 64'(rsp_tdata[RSP_CNT_LSB +: CNT_W]),
                               64'(want.count));
            if (rsp_tdata[RSP_EMPTY_BIT] !== want.empty)
               report_mismatch("is_empty", 64'(rsp_tdata[RSP_EMPTY_BIT]), 64'(want.empty));
            if (rsp_tuser !== want.status)
               report_mismatch("status", 64'(rsp_tuser), 64'(want.status));
         end
      end
   end

   // Watchdog: end the run if no transaction moves on either side for too long.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
      end
      if (idle_cycles >= STALL_LIMIT) begin
         $display("FAIL bucketed_priority_queue_core");
         $finish;
      end
   end

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      test_directed_basics();
      test_lowered_max_level();
      test_fill_and_drain();
      test_random_traffic();
      settle_queue();
      repeat (8) @(posedge clock);
      if (pending_views.size() != 0)
         report_mismatch("results never delivered", 64'(pending_views.size()), 64'h0);
      if (mismatches == 0) begin
         $display("PASS bucketed_priority_queue_core");
      end else begin
         $display("FAIL bucketed_priority_queue_core");
      end
      $finish;
   end

endmodule

[files.f]
hw/rtl/bpq_pkg.sv
hw/rtl/bucketed_priority_queue_core.sv
hw/rtl/bpq_checker.sv
dv/tb_top.sv
